// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, disabled while reset is low
`define DOPF_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dopf check failed");

// concurrent check, active through reset
`define DOPF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("dopf check failed");

`endif

// File: rtl/dopf_pkg.sv
package dopf_pkg;

    localparam int MAX_ROWS   = 256;
    localparam int MAX_COLS   = 256;
    localparam int MAX_AXIS   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int MEM_DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    localparam int CRD_W      = 8;
    localparam int PIX_W      = 16;
    localparam int FRAC_W     = 8;
    localparam int OFF_W      = 16;
    localparam int NUM_OFF    = 4;
    localparam int DVD_W      = OFF_W + FRAC_W;
    localparam int QUO_W      = $clog2(MAX_AXIS) + 1;
    localparam int HI_W       = DVD_W - QUO_W;
    localparam int CMP_W      = (HI_W > PIX_W) ? HI_W : PIX_W;
    localparam int CNT_W      = $clog2(QUO_W);
    localparam int POS_W      = 18;
    localparam int FEAT_W     = 18;

    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 1;

    localparam int S_DATA_W   = 104;
    localparam int S_USER_W   = 1;
    localparam int M_DATA_W   = 24;
    localparam int S_PAD_W    = S_DATA_W - (2 * CRD_W + PIX_W + NUM_OFF * OFF_W + 2);

    localparam int OFF_R1     = 0;
    localparam int OFF_C1     = 1;
    localparam int OFF_R2     = 2;
    localparam int OFF_C2     = 3;

    localparam logic [CFG_W-1:0] NUM_ROWS_RST = CFG_W'(256);
    localparam logic [CFG_W-1:0] NUM_COLS_RST = CFG_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS = 1'b0,
        CFG_NUM_COLS = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_EVAL  = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTER,
        ST_DIVIDE,
        ST_PROBE,
        ST_FINISH
    } t_state;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic [NUM_OFF-1:0][OFF_W-1:0] t_off_vec;

    typedef struct packed {
        logic [S_PAD_W-1:0] pad;
        logic               combine;
        logic               scale_by_depth;
        logic [OFF_W-1:0]   second_col_offset;
        logic [OFF_W-1:0]   second_row_offset;
        logic [OFF_W-1:0]   first_col_offset;
        logic [OFF_W-1:0]   first_row_offset;
        logic [PIX_W-1:0]   pixel_value;
        logic [CRD_W-1:0]   pixel_col;
        logic [CRD_W-1:0]   pixel_row;
    } t_in_data;

    typedef struct packed {
        logic             start;
        logic [PIX_W-1:0] depth;
        t_off_vec         offs;
    } t_div_req;

    typedef struct packed {
        logic     done;
        t_off_vec offs;
    } t_div_rsp;

    function automatic t_pos axis_last(input logic [CFG_W-1:0] r, input int unsigned mx);
        t_pos lim;
        if (r == '0) begin
            lim = t_pos'(1);
        end else if (POS_W'(r) > POS_W'(mx)) begin
            lim = POS_W'(mx);
        end else begin
            lim = POS_W'(r);
        end
        return lim - t_pos'(1);
    endfunction

    function automatic t_pos probe_pos(input logic [CRD_W-1:0] c, input logic [OFF_W-1:0] off);
        t_pos pc;
        t_pos po;
        pc = POS_W'(c);
        po = POS_W'($signed(off));
        return pc + po;
    endfunction

    function automatic t_pos clamp_axis(input t_pos p, input t_pos last);
        t_pos q;
        if (p < t_pos'(0)) begin
            q = t_pos'(0);
        end else if (p > last) begin
            q = last;
        end else begin
            q = p;
        end
        return q;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
    endfunction

endpackage

// File: rtl/dopf_ram.sv
module dopf_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re_a,
    input  logic [ADDR_W-1:0] i_raddr_a,
    output logic [WIDTH-1:0]  o_rdata_a,
    input  logic              i_re_b,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: rtl/dopf_scale.sv
module dopf_scale
    import dopf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [PIX_W-1:0] r_depth;
    logic [PIX_W-1:0] r_rem [NUM_OFF];
    logic [QUO_W-1:0] r_num [NUM_OFF];
    logic [QUO_W-1:0] r_quo [NUM_OFF];
    logic             r_ovf [NUM_OFF];
    logic             r_neg [NUM_OFF];
    t_off_vec         r_res;

    logic [PIX_W-1:0] n_rem0 [NUM_OFF];
    logic [QUO_W-1:0] n_num0 [NUM_OFF];
    logic             n_ovf0 [NUM_OFF];
    logic [PIX_W-1:0] n_rem  [NUM_OFF];
    logic [QUO_W-1:0] n_quo  [NUM_OFF];
    t_off_vec         n_res;

    always_comb begin
        logic [OFF_W-1:0] mag;
        logic [DVD_W-1:0] dvd;
        logic [HI_W-1:0]  hi;
        logic [PIX_W:0]   trial;
        logic             ge;
        logic [QUO_W-1:0] qmag;
        logic [OFF_W-1:0] omag;
        n_res = '0;
        for (int l = 0; l < NUM_OFF; l++) begin
            mag       = i_req.offs[l][OFF_W-1] ? OFF_W'(-i_req.offs[l]) : i_req.offs[l];
            dvd       = {mag, {FRAC_W{1'b0}}};
            hi        = dvd[DVD_W-1:QUO_W];
            n_ovf0[l] = CMP_W'(hi) >= CMP_W'(i_req.depth);
            n_rem0[l] = PIX_W'(hi);
            n_num0[l] = dvd[QUO_W-1:0];

            trial     = {r_rem[l], r_num[l][QUO_W-1]};
            ge        = trial >= {1'b0, r_depth};
            n_rem[l]  = ge ? PIX_W'(trial - {1'b0, r_depth}) : PIX_W'(trial);
            n_quo[l]  = {r_quo[l][QUO_W-2:0], ge};
            qmag      = r_ovf[l] ? {QUO_W{1'b1}} : n_quo[l];
            omag      = OFF_W'(qmag);
            n_res[l]  = r_neg[l] ? OFF_W'(-omag) : omag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_depth <= i_req.depth;
            for (int l = 0; l < NUM_OFF; l++) begin
                r_rem[l] <= n_rem0[l];
                r_num[l] <= n_num0[l];
                r_ovf[l] <= n_ovf0[l];
                r_neg[l] <= i_req.offs[l][OFF_W-1];
            end
        end else if (r_busy) begin
            for (int l = 0; l < NUM_OFF; l++) begin
                r_rem[l] <= n_rem[l];
                r_num[l] <= {r_num[l][QUO_W-2:0], 1'b0};
                r_quo[l] <= n_quo[l];
            end
            if (r_cnt == '0) begin
                r_res <= n_res;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.offs = r_res;

endmodule

// File: rtl/depth_offset_pair_feature_top.sv
// channel   | dir | handshake                      | payload
// ----------+-----+--------------------------------+----------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | tuser: kind; tdata: item fields
// m_axis    | out | m_axis_tvalid / m_axis_tready  | tdata: feature_value
// cfg       | in  | i_cfg_we (no wait)             | i_cfg_index, i_cfg_data
//
// Evaluation with depth scaling and a nonzero center depth runs the four-lane radix-2
// offset divider. Image memory reads (center, then both probes) are registered.
// Reset returns control to idle and sets both size registers to 256; the image is undefined.
// A stalled result holds in the output register; the next result loads only once it is taken.
module depth_offset_pair_feature_top
    import dopf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [7:0] pixel_row, [15:8] pixel_col, [31:16] pixel_value,
    // [47:32] first_row_offset, [63:48] first_col_offset,
    // [79:64] second_row_offset, [95:80] second_col_offset,
    // [96] scale_by_depth, [97] combine, [103:98] zero
    input  logic [S_DATA_W-1:0]  s_axis_tdata,
    // [0] kind
    input  logic [S_USER_W-1:0]  s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [17:0] feature_value, [23:18] zero
    output logic [M_DATA_W-1:0]  m_axis_tdata
);

    t_state            r_state;
    t_state            n_state;
    logic [CFG_W-1:0]  r_num_rows;
    logic [CFG_W-1:0]  r_num_cols;

    logic [CRD_W-1:0]  r_crow;
    logic [CRD_W-1:0]  r_ccol;
    logic              r_center_ok;
    logic              r_scale;
    logic              r_combine;
    t_off_vec          r_off;

    logic              r_out_valid;
    logic [FEAT_W-1:0] r_out_data;

    t_in_data          in_d;
    logic              in_ok;
    logic              acc;
    logic              acc_eval;
    logic              acc_write;
    logic              out_free;
    logic              out_load;
    logic [ADDR_W-1:0] center_addr;

    logic              mem_we;
    logic              mem_re_a;
    logic              mem_re_b;
    logic [ADDR_W-1:0] mem_raddr_a;
    logic [PIX_W-1:0]  mem_rdata_a;
    logic [PIX_W-1:0]  mem_rdata_b;

    logic [PIX_W-1:0]  depth;
    logic              div_start;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    t_pos              row_last;
    t_pos              col_last;
    t_pos              r1_pos;
    t_pos              c1_pos;
    t_pos              r2_pos;
    t_pos              c2_pos;
    logic [ADDR_W-1:0] addr1;
    logic [ADDR_W-1:0] addr2;
    logic [FEAT_W-1:0] feature;

    assign in_d        = t_in_data'(s_axis_tdata);
    assign in_ok       = (int'(in_d.pixel_row) < MAX_ROWS) && (int'(in_d.pixel_col) < MAX_COLS);
    assign center_addr = addr_of(ROW_W'(in_d.pixel_row), COL_W'(in_d.pixel_col));
    assign out_free    = !r_out_valid || m_axis_tready;

    assign acc       = s_axis_tvalid && s_axis_tready;
    assign acc_eval  = acc && (t_kind'(s_axis_tuser[0]) == KIND_EVAL);
    assign acc_write = acc && (t_kind'(s_axis_tuser[0]) == KIND_WRITE);

    assign depth = r_center_ok ? mem_rdata_a : '0;

    assign row_last = axis_last(r_num_rows, MAX_ROWS);
    assign col_last = axis_last(r_num_cols, MAX_COLS);
    assign r1_pos   = clamp_axis(probe_pos(r_crow, r_off[OFF_R1]), row_last);
    assign c1_pos   = clamp_axis(probe_pos(r_ccol, r_off[OFF_C1]), col_last);
    assign r2_pos   = clamp_axis(probe_pos(r_crow, r_off[OFF_R2]), row_last);
    assign c2_pos   = clamp_axis(probe_pos(r_ccol, r_off[OFF_C2]), col_last);
    assign addr1    = addr_of(ROW_W'(r1_pos), COL_W'(c1_pos));
    assign addr2    = addr_of(ROW_W'(r2_pos), COL_W'(c2_pos));

    assign feature = r_combine ? FEAT_W'(mem_rdata_a) + FEAT_W'(mem_rdata_b)
                               : FEAT_W'(mem_rdata_a) - FEAT_W'(mem_rdata_b);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_eval) begin
                    n_state = ST_CENTER;
                end
            end
            ST_CENTER: begin
                n_state = div_start ? ST_DIVIDE : ST_PROBE;
            end
            ST_DIVIDE: begin
                if (div_rsp.done) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = acc_eval ? ST_CENTER : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        mem_re_b      = 1'b0;
        out_load      = 1'b0;
        div_start     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_CENTER: begin
                div_start = r_scale && (depth != '0);
            end
            ST_DIVIDE: begin
            end
            ST_PROBE: begin
                mem_re_b = 1'b1;
            end
            ST_FINISH: begin
                s_axis_tready = out_free;
                out_load      = out_free;
            end
            default: begin
            end
        endcase
        mem_we      = acc_write && in_ok;
        mem_re_a    = acc_eval || (r_state == ST_PROBE);
        mem_raddr_a = (r_state == ST_PROBE) ? addr1 : center_addr;
    end

    assign div_req = '{start: div_start, depth: depth, offs: r_off};

    dopf_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    dopf_ram #(
        .WIDTH  (PIX_W),
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_image (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (center_addr),
        .i_wdata   (in_d.pixel_value),
        .i_re_a    (mem_re_a),
        .i_raddr_a (mem_raddr_a),
        .o_rdata_a (mem_rdata_a),
        .i_re_b    (mem_re_b),
        .i_raddr_b (addr2),
        .o_rdata_b (mem_rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_num_rows  <= NUM_ROWS_RST;
            r_num_cols  <= NUM_COLS_RST;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                    CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_eval) begin
            r_crow      <= in_d.pixel_row;
            r_ccol      <= in_d.pixel_col;
            r_center_ok <= in_ok;
            r_scale     <= in_d.scale_by_depth;
            r_combine   <= in_d.combine;
            r_off       <= {in_d.second_col_offset, in_d.second_row_offset,
                            in_d.first_col_offset, in_d.first_row_offset};
        end else if ((r_state == ST_DIVIDE) && div_rsp.done) begin
            r_off <= div_rsp.offs;
        end
        if (out_load) begin
            r_out_data <= feature;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_DATA_W - FEAT_W){1'b0}}, r_out_data};

endmodule

// File: rtl/dopf_checker.sv
`include "assert_macros.svh"

module dopf_checker
    import dopf_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_USER_W-1:0]  s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_DATA_W-1:0]  m_axis_tdata
);

    // hold a stalled result
    `DOPF_ASSERT_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    `DOPF_ASSERT_RST(a_out_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))

    // an evaluation transfer blocks the next cycle while the center is read
    `DOPF_ASSERT_RST(a_eval_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready)

    // sum of two pixels or difference stays in range
    `DOPF_ASSERT_RST(a_feat_range, i_clk, i_rst_n, m_axis_tvalid |-> !(m_axis_tdata[17] && !m_axis_tdata[16]) && (m_axis_tdata[17:0] != 18'h1FFFF))

    `DOPF_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind depth_offset_pair_feature_top dopf_checker u_checker (.*);
